// ===== hw/rtl/skvt_pkg.sv =====
// Shared types, constants and helpers for the slot key-value table.
`timescale 1ns / 1ps
`default_nettype none
package skvt_pkg;

	localparam int SLOTS       = 16;
	localparam int KEY_BYTES   = 4;
	localparam int VALUE_BYTES = 4;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 4;
	localparam int OP_W    = 2;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
	localparam logic [LEN_W-1:0]  VLEN_MAX  = LEN_W'(VALUE_BYTES);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_UPDATE = 2'd2,
		OP_FIND   = 2'd3
	} skvt_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} skvt_state_t;

	typedef struct packed {
		skvt_op_t          opcode;
		logic [KEY_W-1:0]  key;
		logic [VALUE_W-1:0] value_in;
		logic [LEN_W-1:0]  value_bytes;
	} skvt_req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value;
	} skvt_res_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  addr;
		logic               set_valid;
		logic               clr_valid;
		logic               write_key;
		logic               write_value;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} skvt_wr_t;

	function automatic logic [VALUE_W-1:0] bytes_mask(input logic [LEN_W-1:0] n);
		logic [VALUE_W-1:0] m;
		m = '0;
		for (int b = 0; b < VALUE_W / 8; b++) begin
			m[8*b +: 8] = (n > LEN_W'(b)) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	localparam logic [KEY_W-1:0] KEY_MASK = bytes_mask(LEN_W'(KEY_BYTES));

endpackage
`default_nettype wire

// ===== hw/rtl/skvt_store.sv =====
// Slot store: valid bits in flops, key and value arrays with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module skvt_store
	import skvt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [SLOT_W-1:0]  rd_addr,
	input  wire skvt_wr_t           wr,
	output logic                    rd_valid_q,
	output logic [KEY_W-1:0]        rd_key_q,
	output logic [VALUE_W-1:0]      rd_value_q
);

	logic [SLOTS-1:0]   valid_q;
	logic [KEY_W-1:0]   key_mem   [SLOTS];
	logic [VALUE_W-1:0] value_mem [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (wr.en && wr.set_valid) begin
				valid_q[wr.addr] <= 1'b1;
			end else if (wr.en && wr.clr_valid) begin
				valid_q[wr.addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.write_key) begin
			key_mem[wr.addr] <= wr.key;
		end
		if (wr.en && wr.write_value) begin
			value_mem[wr.addr] <= wr.value;
		end
		rd_key_q   <= key_mem[rd_addr];
		rd_value_q <= value_mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/skvt_scan.sv =====
// Scan sequencer with the shared key comparator that walks all slots per request.
`timescale 1ns / 1ps
`default_nettype none
module skvt_scan
	import skvt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire skvt_req_t          req,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output skvt_res_t               res,
	output logic [SLOT_W-1:0]       rd_addr,
	input  wire logic               rd_valid,
	input  wire logic [KEY_W-1:0]   rd_key,
	input  wire logic [VALUE_W-1:0] rd_value,
	output skvt_wr_t                wr
);

	skvt_state_t        state_q, state_d;
	logic [SLOT_W-1:0]  idx_q;
	logic               cmp_vld_s1;
	logic [SLOT_W-1:0]  cmp_idx_s1;
	skvt_op_t           op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] vin_q;
	logic [VALUE_W-1:0] vmask_q;
	logic               too_long_q;
	logic               ins_done_q;
	logic               ok_q;
	logic [VALUE_W-1:0] vout_q;

	logic               accept;
	logic               match;
	logic               free;
	logic [LEN_W-1:0]   find_len;

	assign accept   = req_valid && req_ready;
	assign match    = cmp_vld_s1 && rd_valid && (rd_key == key_q);
	assign free     = cmp_vld_s1 && !rd_valid;
	assign find_len = (req.value_bytes > VLEN_MAX) ? VLEN_MAX : req.value_bytes;
	assign rd_addr  = idx_q;
	assign res.ok    = ok_q;
	assign res.value = vout_q;

	always_comb begin
		wr             = '0;
		wr.addr        = cmp_idx_s1;
		wr.key         = key_q;
		wr.value       = vin_q;
		case (op_q)
			OP_INSERT: begin
				if (free && !ins_done_q && !too_long_q) begin
					wr.en          = 1'b1;
					wr.set_valid   = 1'b1;
					wr.write_key   = 1'b1;
					wr.write_value = 1'b1;
				end
			end
			OP_DELETE: begin
				if (match) begin
					wr.en        = 1'b1;
					wr.clr_valid = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (match && !too_long_q) begin
					wr.en          = 1'b1;
					wr.write_value = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == SLOT_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			ins_done_q <= 1'b0;
			ok_q       <= 1'b0;
			vout_q     <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= idx_q;
			if (state_q == ST_SCAN) begin
				idx_q <= (idx_q == SLOT_LAST) ? '0 : idx_q + SLOT_W'(1);
			end
			if (accept) begin
				idx_q      <= '0;
				ins_done_q <= 1'b0;
				ok_q       <= (req.opcode == OP_DELETE);
				vout_q     <= '0;
			end else begin
				if (wr.en && wr.set_valid) begin
					ins_done_q <= 1'b1;
					ok_q       <= 1'b1;
				end
				if (op_q == OP_UPDATE && wr.en) begin
					ok_q <= 1'b1;
				end
				if (op_q == OP_FIND && match) begin
					ok_q   <= 1'b1;
					vout_q <= rd_value & vmask_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.opcode;
			key_q      <= req.key & KEY_MASK;
			vin_q      <= req.value_in & bytes_mask(req.value_bytes);
			vmask_q    <= bytes_mask(find_len);
			too_long_q <= (req.value_bytes > VLEN_MAX);
		end
	end

	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && (idx_q != SLOT_LAST) |=> idx_q == $past(idx_q) + SLOT_W'(1))
		else $error("slot index skipped during scan");

	a_single_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ins_done_q && !accept |-> !(wr.en && wr.set_valid))
		else $error("insert wrote more than one slot");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> cmp_vld_s1 && (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("slot write outside scan window");

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DONE))
		else $error("drain did not lead to result");

endmodule
`default_nettype wire

// ===== hw/rtl/slot_key_value_table.sv =====
// Slot key-value table top level: stream ports, scan sequencer, slot store, result register.
// A request passes the scan, drain and done states of the sequencer, then the output register.
// The scan reads one slot per cycle through the single read port of the slot store and one
// shared key comparator; a new request is taken only after the previous result leaves the scan.
// A new request is taken while the previous result still waits in the output register.
// Reset clears all valid bits at once (table empty); keys and values need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module slot_key_value_table
	import skvt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // key[31:0], value_in[63:32], value_bytes[67:64], pad
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // value_out[31:0]
	output logic [0:0]       m_axis_tuser   // ok[0]
);

	skvt_req_t          req;
	skvt_res_t          res;
	skvt_wr_t           wr;
	logic               res_valid;
	logic               res_ready;
	logic [SLOT_W-1:0]  rd_addr;
	logic               rd_valid;
	logic [KEY_W-1:0]   rd_key;
	logic [VALUE_W-1:0] rd_value;
	logic               out_vld_q;
	logic               out_ok_q;
	logic [VALUE_W-1:0] out_value_q;

	assign req.opcode      = skvt_op_t'(s_axis_tuser);
	assign req.key         = s_axis_tdata[31:0];
	assign req.value_in    = s_axis_tdata[63:32];
	assign req.value_bytes = s_axis_tdata[67:64];

	assign res_ready     = !out_vld_q || m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_ok_q;

	skvt_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_valid  (rd_valid),
		.rd_key    (rd_key),
		.rd_value  (rd_value),
		.wr        (wr)
	);

	skvt_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr),
		.wr         (wr),
		.rd_valid_q (rd_valid),
		.rd_key_q   (rd_key),
		.rd_value_q (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_ok_q    <= res.ok;
			out_value_q <= res.value;
		end
	end

endmodule
`default_nettype wire
